FILE: hdl/sdas_pkg.sv
// ----------------------------------------------------------------------------
// sdas_pkg
// Shared types and constants for the sign-magnitude BCD adder/subtractor.
// ----------------------------------------------------------------------------
package sdas_pkg;

  localparam int NumDigits = 16;              // used BCD digits, 1..16
  localparam int DigitsW   = 64;              // packed digit field width
  localparam int QDepth    = 2;               // front-to-back queue depth
  localparam int QPtrW     = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW     = $clog2(QDepth + 1);

  // ones over the used nibbles
  localparam logic [DigitsW-1:0] DigitMask =
    (NumDigits >= 16) ? {DigitsW{1'b1}}
                      : DigitsW'((65'(1) << (4 * NumDigits)) - 65'(1));
  // +6 in every used nibble, the decimal pre-bias for binary add
  localparam logic [DigitsW-1:0] Bias6 = 64'h6666_6666_6666_6666 & DigitMask;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusOverflow = 2'd1,
    StatusInvalid  = 2'd2
  } status_e;

  typedef struct packed {
    logic               req_type;
    logic [DigitsW-1:0] a_digits;
    logic               a_sign;
    logic [DigitsW-1:0] b_digits;
    logic               b_sign;
  } req_t;

  typedef struct packed {
    logic [DigitsW-1:0] sum_digits;
    logic               sum_sign;
    status_e            status;
  } res_t;

  // classified item, front to back
  typedef struct packed {
    logic               invalid;
    logic               op_sub;   // magnitudes are subtracted
    logic               sign;     // sign of the result when ok
    logic [DigitsW-1:0] mag_hi;   // larger magnitude on subtract
    logic [DigitsW-1:0] mag_lo;
  } cls_t;

endpackage

FILE: hdl/signed_decimal_add_sub.sv
// ----------------------------------------------------------------------------
// signed_decimal_add_sub
// Sign-magnitude BCD adder/subtractor: front classifier, queue, back unit.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------
//  request  | start, busy        | req_i  (sdas_pkg::req_t)
//  result   | done_o (strobe)    | res_o  (sdas_pkg::res_t)
//
//  One item per cycle; after its transfer, each item is registered in the
//  queue by the front classify, then in the back add/subtract register.
//  The back unit drains the queue every cycle, so busy stays low in use.
//  Reset clears queue pointers, count and result strobe, not the data registers.
//  The receiver cannot stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module signed_decimal_add_sub (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  sdas_pkg::req_t req_i,
  output logic           done_o,
  output sdas_pkg::res_t res_o
);

  sdas_pkg::cls_t cls_in, cls_out;
  logic           q_empty, q_full;

  sdas_front u_front (
    .req_i (req_i),
    .cls_o (cls_in)
  );

  sdas_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (start),
    .data_i  (cls_in),
    .pop_i   (!q_empty),
    .empty_o (q_empty),
    .full_o  (q_full),
    .data_o  (cls_out)
  );

  sdas_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (!q_empty),
    .cls_i   (cls_out),
    .done_o  (done_o),
    .res_o   (res_o)
  );

  assign busy = q_full;

  // result strobe follows each transfer via the queue and back registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> ##1 done_o)
    else $error("result strobe missing two cycles after transfer");

  // error results carry a zero magnitude and sign
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (res_o.status == sdas_pkg::StatusOverflow ||
               res_o.status == sdas_pkg::StatusInvalid)
    |-> res_o.sum_digits == '0 && !res_o.sum_sign)
    else $error("error result with nonzero payload");

  // no strobe without a queued item the cycle before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(!q_empty))
    else $error("result strobe without queued item");

  // back drains every cycle, so the queue never fills
  assert property (@(posedge clk_i) disable iff (!rst_ni) !q_full)
    else $error("queue filled");

endmodule

FILE: hdl/sdas_front.sv
// ----------------------------------------------------------------------------
// sdas_front
// Classifies a request: digit check, effective sign, magnitude order.
// ----------------------------------------------------------------------------
module sdas_front (
  input  sdas_pkg::req_t req_i,
  output sdas_pkg::cls_t cls_o
);

  logic [sdas_pkg::DigitsW-1:0] a_m, b_m;
  logic                         b_eff;
  logic                         bad;
  logic                         a_lt;

  assign a_m   = req_i.a_digits & sdas_pkg::DigitMask;
  assign b_m   = req_i.b_digits & sdas_pkg::DigitMask;
  assign b_eff = req_i.b_sign ^ req_i.req_type;
  // nibble-wise compare from the top equals a plain unsigned compare
  assign a_lt  = a_m < b_m;

  always_comb begin
    bad = 1'b0;
    for (int i = 0; i < sdas_pkg::NumDigits; i++) begin
      if (a_m[4*i +: 4] > 4'd9 || b_m[4*i +: 4] > 4'd9) begin
        bad = 1'b1;
      end
    end
  end

  always_comb begin
    cls_o.invalid = bad;
    cls_o.op_sub  = req_i.a_sign ^ b_eff;
    if (cls_o.op_sub && a_lt) begin
      cls_o.sign   = b_eff;
      cls_o.mag_hi = b_m;
      cls_o.mag_lo = a_m;
    end else begin
      cls_o.sign   = req_i.a_sign;
      cls_o.mag_hi = a_m;
      cls_o.mag_lo = b_m;
    end
  end

endmodule

FILE: hdl/sdas_queue.sv
// ----------------------------------------------------------------------------
// sdas_queue
// Short register queue of classified items between front and back.
// ----------------------------------------------------------------------------
module sdas_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sdas_pkg::cls_t data_i,
  input  logic           pop_i,
  output logic           empty_o,
  output logic           full_o,
  output sdas_pkg::cls_t data_o
);

  sdas_pkg::cls_t                  mem_q [sdas_pkg::QDepth];
  logic [sdas_pkg::QPtrW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [sdas_pkg::QCntW-1:0]      cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == sdas_pkg::QCntW'(sdas_pkg::QDepth));
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == sdas_pkg::QPtrW'(sdas_pkg::QDepth - 1)) ? '0
                                                                       : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == sdas_pkg::QPtrW'(sdas_pkg::QDepth - 1)) ? '0
                                                                       : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: hdl/sdas_back.sv
// ----------------------------------------------------------------------------
// sdas_back
// Decimal add or subtract of a classified item, registered result.
// ----------------------------------------------------------------------------
module sdas_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  sdas_pkg::cls_t cls_i,
  output logic           done_o,
  output sdas_pkg::res_t res_o
);

  localparam int W = sdas_pkg::DigitsW;

  logic [W:0]   sum, dif, cy, bw;
  logic [W-1:0] add_dig, sub_dig;
  logic         ovf;
  logic         done_q;
  sdas_pkg::res_t res_q, res_d;

  // binary add with +6 per nibble: nibble carries are the decimal carries
  assign sum = {1'b0, cls_i.mag_hi} + {1'b0, cls_i.mag_lo} + {1'b0, sdas_pkg::Bias6};
  assign cy  = sum ^ {1'b0, cls_i.mag_hi ^ cls_i.mag_lo ^ sdas_pkg::Bias6};
  assign dif = {1'b0, cls_i.mag_hi} - {1'b0, cls_i.mag_lo};
  assign bw  = dif ^ {1'b0, cls_i.mag_hi ^ cls_i.mag_lo};
  assign ovf = cy[4*sdas_pkg::NumDigits];

  // nibbles without a carry out drop the bias; borrowing nibbles wrap by ten
  always_comb begin
    for (int i = 0; i < W / 4; i++) begin
      add_dig[4*i +: 4] = cy[4*i+4] ? sum[4*i +: 4] : sum[4*i +: 4] - 4'd6;
      sub_dig[4*i +: 4] = bw[4*i+4] ? dif[4*i +: 4] - 4'd6 : dif[4*i +: 4];
    end
  end

  always_comb begin
    res_d.sum_digits = '0;
    res_d.sum_sign   = 1'b0;
    res_d.status     = sdas_pkg::StatusOk;
    if (cls_i.invalid) begin
      res_d.status = sdas_pkg::StatusInvalid;
    end else if (cls_i.op_sub) begin
      res_d.sum_digits = sub_dig & sdas_pkg::DigitMask;
      res_d.sum_sign   = cls_i.sign;
    end else if (ovf) begin
      res_d.status = sdas_pkg::StatusOverflow;
    end else begin
      res_d.sum_digits = add_dig & sdas_pkg::DigitMask;
      res_d.sum_sign   = cls_i.sign;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: verif/sdas_checker.sv
// ----------------------------------------------------------------------------
// sdas_checker
// Watches the request and result channels of the sign-magnitude BCD
// adder/subtractor, predicts each sum from the request and compares it with
// the result that comes back, in order. Reports mismatches and counts.
// ----------------------------------------------------------------------------
module sdas_checker
  import sdas_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic busy_i,
  input  req_t req_i,
  input  logic done_i,
  input  res_t res_i,
  output int   errors_o,
  output int   pending_o,
  output int   checked_o,
  output int   overflows_o,
  output int   invalids_o
);

  localparam int unsigned DecBase    = 10;
  localparam int unsigned MaxNibbles = 16;
  localparam int          MaxReports = 10;

  res_t expected_sums[$];

  // Signed decimal sum of one request, as the block should report it.
  function automatic res_t predict_sum(input req_t r);
    int unsigned nd;
    int          i;
    int          cmp;
    int unsigned carry;
    int unsigned d;
    int unsigned x;
    int unsigned y;
    logic [DigitsW-1:0] big;
    logic [DigitsW-1:0] sml;
    logic [DigitsW-1:0] mag;
    logic eff_b_sign;
    logic bad;
    logic big_sign;
    res_t o;
    nd = (NumDigits > MaxNibbles) ? MaxNibbles : NumDigits;
    eff_b_sign = r.b_sign ^ r.req_type;
    bad   = 1'b0;
    mag   = '0;
    carry = 0;
    cmp   = 0;
    o.sum_digits = '0;
    o.sum_sign   = 1'b0;
    o.status     = StatusOk;
    for (i = 0; i < nd; i++)
      if (r.a_digits[4*i +: 4] > 9 || r.b_digits[4*i +: 4] > 9) bad = 1'b1;
    if (bad) begin
      o.status = StatusInvalid;
    end else if (r.a_sign == eff_b_sign) begin
      for (i = 0; i < nd; i++) begin
        d = r.a_digits[4*i +: 4] + r.b_digits[4*i +: 4] + carry;
        carry = 0;
        if (d >= DecBase) begin
          d -= DecBase;
          carry = 1;
        end
        mag[4*i +: 4] = d[3:0];
      end
      if (carry != 0) begin
        o.status = StatusOverflow;
      end else begin
        o.sum_digits = mag;
        o.sum_sign   = r.a_sign;
      end
    end else begin
      // magnitude compare from the top digit down
      for (i = nd - 1; i >= 0 && cmp == 0; i--)
        if (r.a_digits[4*i +: 4] != r.b_digits[4*i +: 4])
          cmp = (r.a_digits[4*i +: 4] > r.b_digits[4*i +: 4]) ? 1 : -1;
      // equal magnitudes keep a's sign
      big      = (cmp >= 0) ? r.a_digits : r.b_digits;
      sml      = (cmp >= 0) ? r.b_digits : r.a_digits;
      big_sign = (cmp >= 0) ? r.a_sign : eff_b_sign;
      for (i = 0; i < nd; i++) begin
        x = big[4*i +: 4];
        y = sml[4*i +: 4] + carry;
        carry = 0;
        if (x < y) begin
          d = x + DecBase - y;
          carry = 1;
        end else begin
          d = x - y;
        end
        mag[4*i +: 4] = d[3:0];
      end
      o.sum_digits = mag;
      o.sum_sign   = big_sign;
    end
    return o;
  endfunction

  initial begin
    errors_o    = 0;
    pending_o   = 0;
    checked_o   = 0;
    overflows_o = 0;
    invalids_o  = 0;
  end

  // Results are matched before new requests are queued: a result can never
  // belong to a request transferred at the same edge.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (done_i) begin
        if (expected_sums.size() == 0) begin
          errors_o++;
          if (errors_o <= MaxReports)
            $display("[%0t] unexpected result: digits=%h sign=%b status=%0d",
                     $realtime, res_i.sum_digits, res_i.sum_sign, res_i.status);
        end else begin
          want = expected_sums.pop_front();
          checked_o++;
          if (want.status == StatusOverflow) overflows_o++;
          if (want.status == StatusInvalid) invalids_o++;
          if (res_i.sum_digits !== want.sum_digits || res_i.sum_sign !== want.sum_sign ||
              res_i.status !== want.status) begin
            errors_o++;
            if (errors_o <= MaxReports)
              $display("[%0t] sum mismatch: exp digits=%h sign=%b status=%0d, got digits=%h sign=%b status=%0d",
                       $realtime, want.sum_digits, want.sum_sign, want.status,
                       res_i.sum_digits, res_i.sum_sign, res_i.status);
          end
        end
      end
      if (start_i && !busy_i) expected_sums.push_back(predict_sum(req_i));
      pending_o = expected_sums.size();
    end
  end

endmodule

FILE: verif/tb_signed_decimal_add_sub.sv
// ----------------------------------------------------------------------------
// tb_signed_decimal_add_sub
// Drives directed and random add/subtract requests into the BCD
// adder/subtractor with random gaps and drain pauses; the checker beside
// the block predicts and compares every result. Gives the verdict.
// ----------------------------------------------------------------------------
module tb_signed_decimal_add_sub;
  import sdas_pkg::*;

  localparam int NumRandom     = 1400;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 8;
  localparam logic OpAdd = 1'b0;
  localparam logic OpSub = 1'b1;
  localparam logic [DigitsW-1:0] AllNines = 64'h9999_9999_9999_9999;
  localparam logic [DigitsW-1:0] AllF     = 64'hFFFF_FFFF_FFFF_FFFF;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req;
  logic done_o;
  res_t res_o;

  int errors;
  int pending;
  int checked;
  int overflows;
  int invalids;
  int sent;
  int idle_cycles;

  signed_decimal_add_sub DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .done_o (done_o),
    .res_o  (res_o)
  );

  sdas_checker sum_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .req_i       (req),
    .done_i      (done_o),
    .res_i       (res_o),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked),
    .overflows_o (overflows),
    .invalids_o  (invalids)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // no transfer on either channel for too long means the block is hung
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic req_t mk_req(logic op, logic [DigitsW-1:0] a, logic sa,
                                  logic [DigitsW-1:0] b, logic sb);
    req_t r;
    r.req_type = op;
    r.a_digits = a;
    r.a_sign   = sa;
    r.b_digits = b;
    r.b_sign   = sb;
    return r;
  endfunction

  function automatic logic [DigitsW-1:0] rand_bcd(int unsigned ndig);
    logic [DigitsW-1:0] v;
    int i;
    v = '0;
    for (i = 0; i < ndig && i < NumDigits; i++) v[4*i +: 4] = 4'($urandom_range(0, 9));
    return v;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int unsigned kind;
    int unsigned k;
    logic [DigitsW-1:0] low_mask;
    kind = $urandom_range(0, 99);
    r = mk_req(1'($urandom_range(0, 1)), rand_bcd(NumDigits), 1'($urandom_range(0, 1)),
               rand_bcd(NumDigits), 1'($urandom_range(0, 1)));
    if (kind < 35) begin
      // full-length operands as drawn
    end else if (kind < 55) begin
      r.a_digits = rand_bcd($urandom_range(1, NumDigits));
      r.b_digits = rand_bcd($urandom_range(1, NumDigits));
    end else if (kind < 65) begin
      r.b_digits = r.a_digits;
    end else if (kind < 75) begin
      // heavy top digits, carry out likely on add
      r.a_digits[4*NumDigits-1 -: 4] = 4'($urandom_range(5, 9));
      r.b_digits[4*NumDigits-1 -: 4] = 4'($urandom_range(4, 9));
    end else if (kind < 85) begin
      // shared upper digits, magnitudes differ only low down
      k = $urandom_range(1, NumDigits);
      low_mask = (k >= 16) ? AllF : ((64'd1 << (4 * k)) - 64'd1);
      r.b_digits = (r.a_digits & ~low_mask) | (rand_bcd(k) & low_mask);
    end else if (kind < 93) begin
      k = $urandom_range(0, NumDigits - 1);
      if ($urandom_range(0, 1)) r.a_digits[4*k +: 4] = 4'($urandom_range(10, 15));
      else r.b_digits[4*k +: 4] = 4'($urandom_range(10, 15));
    end else begin
      r.a_digits = {$urandom, $urandom};
      r.b_digits = {$urandom, $urandom};
    end
    return r;
  endfunction

  // holds the request until it is transferred; start stays high afterward
  task automatic send(input req_t r);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk_i); while (busy);
    sent++;
  endtask

  task automatic pause(input int unsigned n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    req_t directed[$];
    int i;
    rst_ni = 1'b0;
    start  = 1'b0;
    req    = '0;
    sent   = 0;
    idle_cycles = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed.push_back(mk_req(OpAdd, '0, 1'b0, '0, 1'b0));
    directed.push_back(mk_req(OpSub, '0, 1'b1, '0, 1'b1));
    directed.push_back(mk_req(OpAdd, '0, 1'b0, '0, 1'b1));
    directed.push_back(mk_req(OpAdd, AllNines, 1'b0, 64'd1, 1'b0));
    directed.push_back(mk_req(OpSub, AllNines, 1'b1, AllNines, 1'b0));
    directed.push_back(mk_req(OpSub, AllNines, 1'b0, AllNines, 1'b0));
    directed.push_back(mk_req(OpAdd, 64'h123, 1'b1, 64'h123, 1'b0));
    directed.push_back(mk_req(OpSub, 64'h1000_0000_0000_0000, 1'b0, 64'd1, 1'b0));
    directed.push_back(mk_req(OpSub, 64'd1, 1'b0, 64'h1000_0000_0000_0000, 1'b0));
    directed.push_back(mk_req(OpSub, 64'h5, 1'b1, 64'h7, 1'b1));
    directed.push_back(mk_req(OpAdd, 64'h5, 1'b0, 64'h5, 1'b0));
    directed.push_back(mk_req(OpAdd, 64'h4, 1'b1, 64'h9, 1'b0));
    directed.push_back(mk_req(OpSub, 64'h3, 1'b1, 64'h8, 1'b0));
    directed.push_back(mk_req(OpAdd, AllF, 1'b0, 64'h1, 1'b0));
    directed.push_back(mk_req(OpAdd, 64'h1, 1'b0, 64'hA000_0000_0000_0000, 1'b0));
    directed.push_back(mk_req(OpSub, 64'h42, 1'b0, 64'h1F, 1'b1));
    // invalid digit must win over a carry out
    directed.push_back(mk_req(OpAdd, 64'hF999_9999_9999_9999, 1'b0, AllNines, 1'b0));
    directed.push_back(mk_req(OpAdd, 64'h9876_5432_1098_7654, 1'b0,
                              64'h0123_4567_8901_2345, 1'b0));
    directed.push_back(mk_req(OpAdd, 64'h4999_9999_9999_9999, 1'b1,
                              64'h5000_0000_0000_0000, 1'b1));
    directed.push_back(mk_req(OpAdd, 64'h5000_0000_0000_0000, 1'b0,
                              64'h5000_0000_0000_0000, 1'b0));
    directed.push_back(mk_req(OpSub, AllF, 1'b1, AllF, 1'b1));
    directed.push_back(mk_req(OpSub, 64'h0909_0909_0909_0909, 1'b1,
                              64'h9090_9090_9090_9090, 1'b0));
    for (i = 0; i < directed.size(); i++) begin
      send(directed[i]);
      if (i % 4 == 3) pause(pick_gap());
    end
    drain();

    for (i = 0; i < NumRandom; i++) begin
      send(rand_req());
      if (i == NumRandom / 2) drain();
      else if ((i / 150) % 3 != 1) pause(pick_gap());
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d requests sent, %0d sums checked (%0d overflow, %0d invalid digit)",
             sent, checked, overflows, invalids);
    $display("%0d mismatches, %0d sums still outstanding", errors, pending);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/sdas_pkg.sv
hdl/sdas_front.sv
hdl/sdas_queue.sv
hdl/sdas_back.sv
hdl/signed_decimal_add_sub.sv
verif/sdas_checker.sv
verif/tb_signed_decimal_add_sub.sv
